// ===== rtl/cje_pkg.sv =====
// Shared widths, register indexes and reset values for the cubic Julia escape-time block.
`timescale 1ns / 1ps

package cje_pkg;

	localparam int CoordW  = 10;
	localparam int WordW   = 32;
	localparam int StepW   = 31;
	localparam int IterW   = 11;
	localparam int PixW    = 20;
	localparam int RegIdxW = 3;

	localparam int DefGridSize = 1024;
	localparam int DefIterCap  = 1024;
	localparam int DefFracBits = 28;

	// Register indexes of the configuration port.
	localparam logic [RegIdxW-1:0] RegCenterRe   = 3'd0;
	localparam logic [RegIdxW-1:0] RegCenterIm   = 3'd1;
	localparam logic [RegIdxW-1:0] RegPixelStep  = 3'd2;
	localparam logic [RegIdxW-1:0] RegConstRe    = 3'd3;
	localparam logic [RegIdxW-1:0] RegConstIm    = 3'd4;
	localparam logic [RegIdxW-1:0] RegEscapeLim  = 3'd5;
	localparam logic [RegIdxW-1:0] RegMaxIter    = 3'd6;

	// Reset values of the registers.
	localparam logic signed [WordW-1:0] RstCenterRe  = 32'sd0;
	localparam logic signed [WordW-1:0] RstCenterIm  = 32'sd0;
	localparam logic [StepW-1:0]        RstPixelStep = 31'd873813;
	localparam logic signed [WordW-1:0] RstConstRe   = 32'sd8053;
	localparam logic signed [WordW-1:0] RstConstIm   = 32'sd273342456;
	localparam logic [WordW-1:0]        RstEscapeLim = 32'd1073741824;
	localparam logic [IterW-1:0]        RstMaxIter   = 11'd100;

	typedef logic signed [WordW-1:0] fix_t;

endpackage

// ===== rtl/cubic_julia_escape_time.sv =====
// Top level of the cubic Julia escape-time engine: sequencer around one shared multiplier.
`timescale 1ns / 1ps

// How to use this block:
// An item is one pixel (col, row). It is taken at a rising edge where start is high
// and busy is low; busy then stays high until the result has been produced. The
// start point is z = ((row - GRID/2) + i*(col - GRID/2)) * pixel_step + center,
// and z = z^3 + c is repeated while the count is below max_iter (capped at
// ITER_CAP) and |z|^2 is below escape_limit. Values are fixed point with FRAC_BITS
// fraction bits, z and c signed; products are floored and saturated to 32 bits.
// The result (pixel_index, iterations, bounded) is shown for exactly one cycle
// with done high. The receiver cannot stall, so the result must be taken then.
// Datapath: one 32x32 multiplier is shared by every product. The start point is set up
// from the real and then the imaginary product; each iteration issues seven products,
// takes the last product and then updates z, and an item ends at the loop test, which
// follows the squares of the current z.
// busy falls in the same cycle that done is raised, and a new item may be taken
// right then. Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at
// the edge and belong to idle periods. Reset loads the default view and constant,
// clears the sequencer and holds done low.
module cubic_julia_escape_time
	import cje_pkg::*;
#(
	parameter int GRID_SIZE = DefGridSize,
	parameter int ITER_CAP  = DefIterCap,
	parameter int FRAC_BITS = DefFracBits
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [CoordW-1:0]    col,
	input  logic [CoordW-1:0]    row,
	input  logic                 cfg_we,
	input  logic [RegIdxW-1:0]   cfg_index,
	input  logic [WordW-1:0]     cfg_wdata,
	output logic                 done,
	output logic [PixW-1:0]      pixel_index,
	output logic [IterW-1:0]     iterations,
	output logic                 bounded
);

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StInit = 2'd1;
	localparam logic [1:0] StIter = 2'd2;

	localparam logic [3:0] PhLast = 4'd8;
	localparam logic signed [WordW-1:0] HalfGrid = 32'(GRID_SIZE / 2);
	localparam logic signed [63:0] Max32 = 64'sd2147483647;
	localparam logic signed [63:0] Min32 = -64'sd2147483648;

	// Saturate a wide signed value to the 32-bit range.
	function automatic fix_t sat32(input logic signed [63:0] v);
		if (v > Max32) begin
			return fix_t'(Max32[WordW-1:0]);
		end else if (v < Min32) begin
			return fix_t'(Min32[WordW-1:0]);
		end
		return fix_t'(v[WordW-1:0]);
	endfunction

	// Fixed-point product: floor by the fraction width, then saturate.
	function automatic fix_t fx(input logic signed [63:0] p);
		return sat32(p >>> FRAC_BITS);
	endfunction

	// Configuration registers.
	fix_t                 center_re_q, center_im_q, const_re_q, const_im_q;
	logic [StepW-1:0]     pixel_step_q;
	logic [WordW-1:0]     escape_lim_q;
	logic [IterW-1:0]     max_iter_q;

	// Sequencer and datapath registers.
	logic [1:0]           state_q;
	logic [3:0]           phase_q;
	logic [CoordW-1:0]    col_q, row_q;
	logic [IterW-1:0]     limit_q, n_q;
	fix_t                 re_q, im_q, re2_q, im2_q, t_q, re3_q, rri_q, im3_q, rii_q;
	logic signed [63:0]   rr_q, prod_q;
	logic [WordW-1:0]     mag_q;
	logic                 done_q, bounded_q;
	logic [PixW-1:0]      pixel_index_q;
	logic [IterW-1:0]     iterations_q;

	fix_t                 mul_a, mul_b;
	logic                 accept;
	logic [IterW-1:0]     limit_d;
	logic [63:0]          mag_sum;
	logic [63:0]          mag_shift;
	logic signed [63:0]   nre_wide, nim_wide;

	assign accept = start && (state_q == StIdle);
	assign busy   = (state_q != StIdle);

	assign limit_d = (32'(max_iter_q) > ITER_CAP) ? IterW'(ITER_CAP) : max_iter_q;

	// Operand select for the shared multiplier.
	always_comb begin
		mul_a = re_q;
		mul_b = re_q;
		if (state_q == StInit) begin
			mul_a = fix_t'($signed({22'b0, (phase_q == 4'd0) ? row_q : col_q})) - HalfGrid;
			mul_b = fix_t'({1'b0, pixel_step_q});
		end else begin
			case (phase_q)
				4'd0:    begin mul_a = re_q;  mul_b = re_q; end
				4'd1:    begin mul_a = im_q;  mul_b = im_q; end
				4'd2:    begin mul_a = re_q;  mul_b = im_q; end
				4'd3:    begin mul_a = re2_q; mul_b = re_q; end
				4'd4:    begin mul_a = re2_q; mul_b = im_q; end
				4'd5:    begin mul_a = im2_q; mul_b = im_q; end
				4'd6:    begin mul_a = t_q;   mul_b = im_q; end
				default: begin mul_a = re_q;  mul_b = re_q; end
			endcase
		end
	end

	// |z|^2 from the two exact squares, floored and saturated to 32 bits unsigned.
	assign mag_sum   = 64'(rr_q) + 64'(prod_q);
	assign mag_shift = mag_sum >> FRAC_BITS;

	// Next z from the registered partial products.
	assign nre_wide = 64'(re3_q) - (64'(rii_q) + (64'(rii_q) <<< 1)) + 64'(const_re_q);
	assign nim_wide = (64'(rri_q) + (64'(rri_q) <<< 1)) - 64'(im3_q) + 64'(const_im_q);

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_re_q  <= RstCenterRe;
			center_im_q  <= RstCenterIm;
			pixel_step_q <= RstPixelStep;
			const_re_q   <= RstConstRe;
			const_im_q   <= RstConstIm;
			escape_lim_q <= RstEscapeLim;
			max_iter_q   <= RstMaxIter;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegCenterRe:  center_re_q  <= fix_t'(cfg_wdata);
				RegCenterIm:  center_im_q  <= fix_t'(cfg_wdata);
				RegPixelStep: pixel_step_q <= cfg_wdata[StepW-1:0];
				RegConstRe:   const_re_q   <= fix_t'(cfg_wdata);
				RegConstIm:   const_im_q   <= fix_t'(cfg_wdata);
				RegEscapeLim: escape_lim_q <= cfg_wdata;
				RegMaxIter:   max_iter_q   <= cfg_wdata[IterW-1:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			phase_q <= '0;
			done_q  <= 1'b0;
			n_q     <= '0;
			re_q    <= '0;
			im_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				StIdle: begin
					if (accept) begin
						state_q       <= StInit;
						phase_q       <= '0;
						col_q         <= col;
						row_q         <= row;
						limit_q       <= limit_d;
						pixel_index_q <= PixW'(32'(GRID_SIZE) * 32'(col) + 32'(row));
					end
				end
				StInit: begin
					// Phase 0 starts the real product, 1 takes it and starts the imaginary one.
					if (phase_q == 4'd1) begin
						re_q <= sat32(prod_q + 64'(center_re_q));
					end
					if (phase_q == 4'd2) begin
						im_q    <= sat32(prod_q + 64'(center_im_q));
						n_q     <= '0;
						state_q <= StIter;
						phase_q <= '0;
					end else begin
						phase_q <= phase_q + 4'd1;
					end
				end
				StIter: begin
					phase_q <= phase_q + 4'd1;
					// Each product lands in the cycle after its operands were selected.
					case (phase_q)
						4'd1: begin
							rr_q  <= prod_q;
							re2_q <= fx(prod_q);
						end
						4'd2: begin
							im2_q <= fx(prod_q);
							mag_q <= (mag_shift[63:WordW] != '0) ? '1 : mag_shift[WordW-1:0];
						end
						4'd3: begin
							t_q <= fx(prod_q);
							// The loop test runs before each step only.
							if ((n_q >= limit_q) || (mag_q >= escape_lim_q)) begin
								state_q      <= StIdle;
								phase_q      <= '0;
								done_q       <= 1'b1;
								iterations_q <= n_q;
								bounded_q    <= (n_q >= limit_q);
							end
						end
						4'd4: re3_q <= fx(prod_q);
						4'd5: rri_q <= fx(prod_q);
						4'd6: im3_q <= fx(prod_q);
						4'd7: rii_q <= fx(prod_q);
						PhLast: begin
							re_q    <= sat32(nre_wide);
							im_q    <= sat32(nim_wide);
							n_q     <= n_q + 1'b1;
							phase_q <= '0;
						end
						default: ;
					endcase
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign pixel_index = pixel_index_q;
	assign iterations  = iterations_q;
	assign bounded     = bounded_q;

endmodule

// ===== rtl/cje_checker.sv =====
// Port-level checker for the cubic Julia escape-time block and its bind.
`timescale 1ns / 1ps

module cje_checker
	import cje_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// A result only comes out of an item in progress.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without an item in progress");

	// The block is free again in the cycle that shows the result.
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy still high while result is shown");

	// An accepted item makes the block busy and gives no immediate result.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted item did not start work");

endmodule

bind cubic_julia_escape_time cje_checker u_cje_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
